>>> sv/cfgl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the cube face grid location block.
// No dependencies; every other file imports this package.
package cfgl_pkg;

  localparam int CoordWidth     = 24;
  localparam int CfgWidth       = 13;
  localparam int IdxWidth       = 12;
  localparam int FaceWidth      = 3;
  localparam int MaxGridDefault = 4096;
  localparam logic [CfgWidth-1:0] GridSizeReset = CfgWidth'(256);

  typedef enum logic [FaceWidth-1:0] {
    FacePosX = 3'd0,
    FaceNegX = 3'd1,
    FacePosY = 3'd2,
    FaceNegY = 3'd3,
    FacePosZ = 3'd4,
    FaceNegZ = 3'd5
  } cfgl_face_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] dir_x;
    logic signed [CoordWidth-1:0] dir_y;
    logic signed [CoordWidth-1:0] dir_z;
  } cfgl_dir_t;

  typedef struct packed {
    logic                 valid_res;
    logic [FaceWidth-1:0] face;
    logic [IdxWidth-1:0]  grid_col;
    logic [IdxWidth-1:0]  grid_row;
  } cfgl_res_t;

  // Control that rides alongside the payload through the pipeline.
  typedef struct packed {
    logic                 vld;
    logic                 nz;
    logic [FaceWidth-1:0] face;
  } cfgl_side_t;

endpackage

>>> sv/cfgl_face_sel.sv
`timescale 1ns / 1ps
// Front stage: major axis pick, face code and the two index numerators.
// Depends on cfgl_pkg.
module cfgl_face_sel import cfgl_pkg::*; #(
  parameter int SizeW = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  cfgl_dir_t             dir_i,
  input  logic [SizeW-1:0]      size_i,
  output cfgl_side_t            side_o,
  output logic [CoordWidth-1:0] major_o,
  output logic [CoordWidth:0]   num_col_o,
  output logic [CoordWidth:0]   num_row_o,
  output logic [SizeW-1:0]      size_o
);

  localparam int CW = CoordWidth;

  logic [CW-1:0]        ax, ay, az, major;
  logic signed [CW-1:0] col_src, row_src;
  logic                 col_neg, row_neg;
  cfgl_face_e           face;

  logic                 vld_q;
  logic                 nz_q;
  cfgl_face_e           face_q;
  logic [CW-1:0]        major_q;
  logic [CW:0]          num_col_q, num_row_q;
  logic [SizeW-1:0]     size_q;

  // m + a or m - a; the result lies in [0, 2m].
  function automatic logic [CW:0] numer(input logic [CW-1:0] m,
                                        input logic signed [CW-1:0] src,
                                        input logic neg);
    logic signed [CW+1:0] mx;
    logic signed [CW+1:0] sx;
    logic signed [CW+1:0] r;
    mx = $signed({2'b00, m});
    sx = {{2{src[CW-1]}}, src};
    r  = neg ? (mx - sx) : (mx + sx);
    return r[CW:0];
  endfunction

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(~$unsigned(v) + 1'b1) : $unsigned(v);
  endfunction

  always_comb begin
    ax = mag(dir_i.dir_x);
    ay = mag(dir_i.dir_y);
    az = mag(dir_i.dir_z);
    // Ties go to x, then y, then z.
    if (ax >= ay && ax >= az) begin
      major   = ax;
      row_src = dir_i.dir_z;
      row_neg = 1'b0;
      col_src = dir_i.dir_y;
      if (dir_i.dir_x[CW-1]) begin
        face    = FaceNegX;
        col_neg = 1'b1;
      end else begin
        face    = FacePosX;
        col_neg = 1'b0;
      end
    end else if (ay >= az) begin
      major   = ay;
      row_src = dir_i.dir_z;
      row_neg = 1'b0;
      col_src = dir_i.dir_x;
      if (dir_i.dir_y[CW-1]) begin
        face    = FaceNegY;
        col_neg = 1'b0;
      end else begin
        face    = FacePosY;
        col_neg = 1'b1;
      end
    end else begin
      major   = az;
      col_src = dir_i.dir_x;
      col_neg = 1'b1;
      row_src = dir_i.dir_y;
      if (dir_i.dir_z[CW-1]) begin
        face    = FaceNegZ;
        row_neg = 1'b0;
      end else begin
        face    = FacePosZ;
        row_neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nz_q      <= (ax | ay | az) != '0;
    face_q    <= face;
    major_q   <= major;
    num_col_q <= numer(major, col_src, col_neg);
    num_row_q <= numer(major, row_src, row_neg);
    size_q    <= size_i;
  end

  assign side_o    = '{vld: vld_q, nz: nz_q, face: face_q};
  assign major_o   = major_q;
  assign num_col_o = num_col_q;
  assign num_row_o = num_row_q;
  assign size_o    = size_q;

endmodule

>>> sv/cfgl_div_cell.sv
`timescale 1ns / 1ps
// One cell of the restoring divider chain: resolves one quotient bit for
// the column and the row division. Depends on cfgl_pkg.
module cfgl_div_cell import cfgl_pkg::*; #(
  parameter int ProdW = 38,
  parameter int DivW  = 25,
  parameter int QuoW  = 13,
  parameter int Bit   = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfgl_side_t       side_i,
  input  logic [ProdW-1:0] rem_col_i,
  input  logic [ProdW-1:0] rem_row_i,
  input  logic [DivW-1:0]  div_i,
  input  logic [QuoW-1:0]  q_col_i,
  input  logic [QuoW-1:0]  q_row_i,
  input  logic [QuoW-1:0]  size_i,
  output cfgl_side_t       side_o,
  output logic [ProdW-1:0] rem_col_o,
  output logic [ProdW-1:0] rem_row_o,
  output logic [DivW-1:0]  div_o,
  output logic [QuoW-1:0]  q_col_o,
  output logic [QuoW-1:0]  q_row_o,
  output logic [QuoW-1:0]  size_o
);

  logic [ProdW-1:0] div_ext, div_sh;
  logic             ge_col, ge_row;
  logic [QuoW-1:0]  q_col_d, q_row_d;
  logic             vld_q;
  cfgl_side_t       side_q;
  logic [ProdW-1:0] rem_col_q, rem_row_q;
  logic [DivW-1:0]  div_q;
  logic [QuoW-1:0]  q_col_q, q_row_q, size_q;

  assign div_ext = ProdW'(div_i);
  assign div_sh  = div_ext << Bit;
  assign ge_col  = (rem_col_i >> Bit) >= div_ext;
  assign ge_row  = (rem_row_i >> Bit) >= div_ext;

  // Insert this cell's quotient bit into the partial quotients.
  always_comb begin
    q_col_d      = q_col_i;
    q_row_d      = q_row_i;
    q_col_d[Bit] = ge_col;
    q_row_d[Bit] = ge_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= side_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q    <= side_i;
    rem_col_q <= ge_col ? (rem_col_i - div_sh) : rem_col_i;
    rem_row_q <= ge_row ? (rem_row_i - div_sh) : rem_row_i;
    q_col_q   <= q_col_d;
    q_row_q   <= q_row_d;
    div_q     <= div_i;
    size_q    <= size_i;
  end

  assign side_o    = '{vld: vld_q, nz: side_q.nz, face: side_q.face};
  assign rem_col_o = rem_col_q;
  assign rem_row_o = rem_row_q;
  assign div_o     = div_q;
  assign q_col_o   = q_col_q;
  assign q_row_o   = q_row_q;
  assign size_o    = size_q;

endmodule

>>> sv/cube_face_grid_location.sv
`timescale 1ns / 1ps
// Cube face grid location: face and grid cell of a 3D direction.
// Pipeline: face select register, scaling register, a divider chain with one cell
// per quotient bit, and the result register that drives the result strobe.
// Throughput: one transaction per cycle; busy stays low and results cannot stall.
// Reset: asynchronous, active low; clears the pipeline valids, grid_size to 256.
// Depends on cfgl_pkg, cfgl_face_sel and cfgl_div_cell.
module cube_face_grid_location import cfgl_pkg::*; #(
  parameter int MAX_GRID = MaxGridDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cfgl_dir_t           dir_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgWidth-1:0] cfg_data_i,
  output logic                res_valid_o,
  output cfgl_res_t           res_o
);

  // Quotient never exceeds the grid size, so it is sized to hold MAX_GRID itself.
  localparam int QuoW  = $clog2(MAX_GRID + 1);
  localparam int DivW  = CoordWidth + 1;
  localparam int ProdW = CoordWidth + 1 + QuoW;

  logic [CfgWidth-1:0] grid_size_q;
  logic [31:0]         grid_ext;
  logic [QuoW-1:0]     size_eff;

  cfgl_side_t            s1_side;
  logic [CoordWidth-1:0] s1_major;
  logic [CoordWidth:0]   s1_num_col, s1_num_row;
  logic [QuoW-1:0]       s1_size;

  logic                  s2_vld_q;
  cfgl_side_t            s2_side_q;
  logic [ProdW-1:0]      s2_prod_col_q, s2_prod_row_q;
  logic [DivW-1:0]       s2_div_q;
  logic [QuoW-1:0]       s2_size_q;

  // Taps between divider cells; tap 0 feeds the first cell.
  cfgl_side_t       tap_side    [QuoW+1];
  logic [ProdW-1:0] tap_rem_col [QuoW+1];
  logic [ProdW-1:0] tap_rem_row [QuoW+1];
  logic [DivW-1:0]  tap_div     [QuoW+1];
  logic [QuoW-1:0]  tap_q_col   [QuoW+1];
  logic [QuoW-1:0]  tap_q_row   [QuoW+1];
  logic [QuoW-1:0]  tap_size    [QuoW+1];

  logic [QuoW-1:0]  idx_col, idx_row;
  logic             res_valid_q;
  cfgl_res_t        res_d, res_q;

  // The block never stalls: take every transaction and every register write.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GridSizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      grid_size_q <= cfg_data_i;
    end
  end

  // Treat a zero grid size as one and saturate at MAX_GRID.
  always_comb begin
    grid_ext = 32'(grid_size_q);
    if (grid_ext == 32'd0) begin
      size_eff = QuoW'(1);
    end else if (grid_ext > 32'(MAX_GRID)) begin
      size_eff = QuoW'(MAX_GRID);
    end else begin
      size_eff = QuoW'(grid_ext);
    end
  end

  // Stage 1: pick the face and form the numerators m + a or m - a.
  cfgl_face_sel #(
    .SizeW(QuoW)
  ) u_face_sel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (start && !busy),
    .dir_i     (dir_i),
    .size_i    (size_eff),
    .side_o    (s1_side),
    .major_o   (s1_major),
    .num_col_o (s1_num_col),
    .num_row_o (s1_num_row),
    .size_o    (s1_size)
  );

  // Stage 2: scale both numerators by the grid size; the divisor is 2m.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_side.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_side_q     <= s1_side;
    s2_prod_col_q <= ProdW'(s1_num_col) * ProdW'(s1_size);
    s2_prod_row_q <= ProdW'(s1_num_row) * ProdW'(s1_size);
    s2_div_q      <= {s1_major, 1'b0};
    s2_size_q     <= s1_size;
  end

  assign tap_side[0]    = '{vld: s2_vld_q, nz: s2_side_q.nz, face: s2_side_q.face};
  assign tap_rem_col[0] = s2_prod_col_q;
  assign tap_rem_row[0] = s2_prod_row_q;
  assign tap_div[0]     = s2_div_q;
  assign tap_q_col[0]   = '0;
  assign tap_q_row[0]   = '0;
  assign tap_size[0]    = s2_size_q;

  // Divider chain: cell i settles quotient bit QuoW-1-i, most significant first.
  for (genvar i = 0; i < QuoW; i++) begin : g_cell
    cfgl_div_cell #(
      .ProdW (ProdW),
      .DivW  (DivW),
      .QuoW  (QuoW),
      .Bit   (QuoW - 1 - i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .side_i    (tap_side[i]),
      .rem_col_i (tap_rem_col[i]),
      .rem_row_i (tap_rem_row[i]),
      .div_i     (tap_div[i]),
      .q_col_i   (tap_q_col[i]),
      .q_row_i   (tap_q_row[i]),
      .size_i    (tap_size[i]),
      .side_o    (tap_side[i+1]),
      .rem_col_o (tap_rem_col[i+1]),
      .rem_row_o (tap_rem_row[i+1]),
      .div_o     (tap_div[i+1]),
      .q_col_o   (tap_q_col[i+1]),
      .q_row_o   (tap_q_row[i+1]),
      .size_o    (tap_size[i+1])
    );
  end

  // Output stage: clamp an index that reached the grid size, drop the fields
  // of a zero vector to zero.
  always_comb begin
    idx_col = (tap_q_col[QuoW] == tap_size[QuoW]) ? (tap_size[QuoW] - 1'b1)
                                                  : tap_q_col[QuoW];
    idx_row = (tap_q_row[QuoW] == tap_size[QuoW]) ? (tap_size[QuoW] - 1'b1)
                                                  : tap_q_row[QuoW];
    if (tap_side[QuoW].nz) begin
      res_d.valid_res = 1'b1;
      res_d.face      = tap_side[QuoW].face;
      res_d.grid_col  = IdxWidth'(idx_col);
      res_d.grid_row  = IdxWidth'(idx_row);
    end else begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= tap_side[QuoW].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> sv/cfgl_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the cube face grid location block, bound to the top.
// Depends on cfgl_pkg and cube_face_grid_location.
module cfgl_checker import cfgl_pkg::*; #(
  parameter int MaxGrid = MaxGridDefault
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input cfgl_dir_t dir_i,
  input logic      res_valid_o,
  input cfgl_res_t res_o
);

  localparam int Lat = $clog2(MaxGrid + 1) + 3;

  // Every accepted transaction yields one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat res_valid_o)
    else $error("accepted transaction gave no result at the expected cycle");

  // No result without a transaction accepted at the matching cycle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy, Lat))
    else $error("result strobe without a matching transaction");

  // valid_res reflects whether that direction was non-zero.
  a_valid_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.valid_res == $past(dir_i != '0, Lat)))
    else $error("valid_res does not match the direction");

  // A zero vector reports all fields zero; a valid face code stays in range.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.valid_res ? (res_o.face <= FaceNegZ)
                                     : (res_o.face == '0 && res_o.grid_col == '0
                                        && res_o.grid_row == '0)))
    else $error("result fields inconsistent with valid_res");

endmodule

bind cube_face_grid_location cfgl_checker #(.MaxGrid(MAX_GRID)) u_cfgl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .dir_i       (dir_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

>>> tb/tb_cube_face_grid_location.sv
`timescale 1ns / 1ps
// Self-checking bench for cube_face_grid_location: face and grid cell per direction.
// Depends on cfgl_pkg and the block itself; a directed table is followed by random traffic.
module tb_cube_face_grid_location;
  import cfgl_pkg::*;

  localparam int LatencyCycles = 16;     // start to result strobe at the default size
  localparam int WatchdogLimit = 2000;   // quiet cycles before the run is declared hung
  localparam int ItemsPerPhase = 172;

  // One row of the directed table: the direction, and a typed-in cell where one is obvious.
  typedef struct {
    cfgl_dir_t dir;
    bit        typed;
    cfgl_res_t exp_res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_drv = 1'b0;
  logic                busy;
  cfgl_dir_t           dir_drv = '0;
  logic                cfg_valid_drv = 1'b0;
  logic                cfg_ready;
  logic [CfgWidth-1:0] cfg_data_drv = '0;
  logic                res_valid;
  cfgl_res_t           res;

  // Bench copy of the grid_size register, updated on each accepted write.
  logic [CfgWidth-1:0] grid_shadow = GridSizeReset;
  // Expected cells, oldest first, and the typed-in hint travelling with each request.
  cfgl_res_t           cell_q[$];
  dir_row_t            hint_q[$];
  dir_row_t            dir_tab[$];
  int                  idle_pct = 0;
  int                  mismatches = 0;
  int                  quiet_cycles = 0;

  cube_face_grid_location i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start_drv),
    .busy        (busy),
    .dir_i       (dir_drv),
    .cfg_valid_i (cfg_valid_drv),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data_drv),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // floor((m + a) * size / (2m)), held at size - 1 when the minor equals the major.
  function automatic longint cell_index(longint m, longint a, longint size);
    longint idx;
    idx = ((m + a) * size) / (2 * m);
    if (idx >= size) idx = size - 1;
    return idx;
  endfunction

  // Predict the face and cell of one direction under the given grid size.
  function automatic cfgl_res_t locate_cell(cfgl_dir_t d, logic [CfgWidth-1:0] gs);
    longint    x, y, z, ax, ay, az, m, col_a, row_a, size;
    cfgl_res_t r;
    x = longint'(signed'(d.dir_x));
    y = longint'(signed'(d.dir_y));
    z = longint'(signed'(d.dir_z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    size = longint'(gs);
    if (size == 0) size = 1;
    if (size > MaxGridDefault) size = MaxGridDefault;
    r = '0;
    if (ax == 0 && ay == 0 && az == 0) return r;
    r.valid_res = 1'b1;
    // Ties favor x, then y.
    if (ax >= ay && ax >= az) begin
      m = ax;
      row_a = z;
      if (x < 0) begin
        r.face = FaceNegX;
        col_a = -y;
      end else begin
        r.face = FacePosX;
        col_a = y;
      end
    end else if (ay >= az) begin
      m = ay;
      row_a = z;
      if (y < 0) begin
        r.face = FaceNegY;
        col_a = x;
      end else begin
        r.face = FacePosY;
        col_a = -x;
      end
    end else begin
      m = az;
      col_a = -x;
      if (z < 0) begin
        r.face = FaceNegZ;
        row_a = y;
      end else begin
        r.face = FacePosZ;
        row_a = -y;
      end
    end
    r.grid_col = IdxWidth'(cell_index(m, col_a, size));
    r.grid_row = IdxWidth'(cell_index(m, row_a, size));
    return r;
  endfunction

  // Signed random value of the given width, 1 to 24 bits.
  function automatic int rand_coord(int bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  // Component drawn from the range ends, values right around zero, or the full range at random.
  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0:       return -8388608;
      1:       return 8388607;
      2:       return 0;
      3:       return 1;
      4:       return -1;
      default: return rand_coord(CoordWidth);
    endcase
  endfunction

  // Random direction: mostly full range, with a good share of ties, clamps and extremes.
  function automatic cfgl_dir_t rand_dir();
    int        c[3];
    int        w, k;
    cfgl_dir_t d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        foreach (c[i]) c[i] = rand_coord(CoordWidth);
      end
      4: begin
        // tiny values: ties everywhere, zero vector now and then
        foreach (c[i]) c[i] = int'($urandom_range(0, 16)) - 8;
      end
      5: begin
        w = $urandom_range(1, CoordWidth);
        foreach (c[i]) c[i] = rand_coord(w);
      end
      6: begin
        // minor equal to the major in magnitude: tie or clamp to the last cell
        c[0] = rand_coord(CoordWidth);
        c[1] = $urandom_range(0, 1) ? c[0] : -c[0];
        c[2] = rand_coord($urandom_range(1, CoordWidth));
      end
      7: begin
        foreach (c[i]) c[i] = edge_coord();
      end
      default: begin
        c[0] = rand_coord(CoordWidth);
        c[1] = rand_coord(CoordWidth);
        c[2] = rand_coord(12);
      end
    endcase
    // rotate so every axis gets to be the major one
    k = $urandom_range(0, 2);
    d.dir_x = CoordWidth'(c[k]);
    d.dir_y = CoordWidth'(c[(k + 1) % 3]);
    d.dir_z = CoordWidth'(c[(k + 2) % 3]);
    return d;
  endfunction

  function automatic void add_row(int x, int y, int z, bit typed, cfgl_res_t exp_res);
    dir_row_t row;
    row.dir.dir_x = CoordWidth'(x);
    row.dir.dir_y = CoordWidth'(y);
    row.dir.dir_z = CoordWidth'(z);
    row.typed = typed;
    row.exp_res = exp_res;
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // Present one direction after a random idle gap, and hold it until accepted.
  task automatic send_dir(input dir_row_t row);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_drv <= 1'b0;
      dir_drv.dir_x <= CoordWidth'($urandom);
      dir_drv.dir_y <= CoordWidth'($urandom);
      dir_drv.dir_z <= CoordWidth'($urandom);
      @(posedge clk_i);
    end
    hint_q.insert(hint_q.size(), row);
    start_drv <= 1'b1;
    dir_drv <= row.dir;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start, drain the pipeline, then write grid_size over the config channel.
  task automatic write_grid(input logic [CfgWidth-1:0] value);
    start_drv <= 1'b0;
    @(posedge clk_i);
    while (cell_q.size() != 0) @(posedge clk_i);
    cfg_valid_drv <= 1'b1;
    cfg_data_drv <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid_drv <= 1'b0;
  endtask

  // Monitor: check strobed results, predict on accepted requests, track config writes.
  always @(posedge clk_i) begin
    cfgl_res_t want;
    dir_row_t  row;
    if (rst_ni) begin
      if (res_valid) begin
        if (cell_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", res);
        end else begin
          want = cell_q.pop_front();
          if (res.valid_res !== want.valid_res || res.face !== want.face ||
              res.grid_col !== want.grid_col || res.grid_row !== want.grid_row) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: valid %0d/%0d face %0d/%0d col %0d/%0d row %0d/%0d (exp/act)",
                       want.valid_res, res.valid_res, want.face, res.face,
                       want.grid_col, res.grid_col, want.grid_row, res.grid_row);
          end
        end
      end
      if (start_drv && !busy) begin
        row = hint_q.pop_front();
        want = row.typed ? row.exp_res : locate_cell(dir_drv, grid_shadow);
        cell_q.insert(cell_q.size(), want);
      end
      if (cfg_valid_drv && cfg_ready) grid_shadow = cfg_data_drv;
    end
  end

  // Watchdog: count cycles in which no transaction of any kind completes.
  always @(posedge clk_i) begin
    if (res_valid || (start_drv && !busy) || (cfg_valid_drv && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CfgWidth-1:0] grid_plan[9];
    int                  idle_plan[3];
    dir_row_t            row;
    grid_plan = '{CfgWidth'(4096), CfgWidth'(3), CfgWidth'(8191), CfgWidth'(0), CfgWidth'(1),
                  CfgWidth'(2), CfgWidth'(4095), CfgWidth'(100), CfgWidth'(256)};
    idle_plan = '{0, 85, 38};

    // Directed table, run at the reset grid size of 256 cells.
    add_row(0, 0, 0, 1, '{1'b0, 3'd0, 12'd0, 12'd0});             // zero vector
    add_row(1, 0, 0, 1, '{1'b1, FacePosX, 12'd128, 12'd128});
    add_row(-1, 0, 0, 1, '{1'b1, FaceNegX, 12'd128, 12'd128});
    add_row(0, 1, 0, 1, '{1'b1, FacePosY, 12'd128, 12'd128});
    add_row(0, -1, 0, 1, '{1'b1, FaceNegY, 12'd128, 12'd128});
    add_row(0, 0, 1, 1, '{1'b1, FacePosZ, 12'd128, 12'd128});
    add_row(0, 0, -1, 1, '{1'b1, FaceNegZ, 12'd128, 12'd128});
    // all three at the top of the range: tie to x, both indices clamped
    add_row(8388607, 8388607, 8388607, 1, '{1'b1, FacePosX, 12'd255, 12'd255});
    // all three at the bottom: tie to -x, column clamped, row at zero
    add_row(-8388608, -8388608, -8388608, 1, '{1'b1, FaceNegX, 12'd255, 12'd0});
    add_row(-8388608, 8388607, 0, 1, '{1'b1, FaceNegX, 12'd0, 12'd128});
    add_row(0, 0, -8388608, 1, '{1'b1, FaceNegZ, 12'd128, 12'd128});
    add_row(5, 5, 0, 1, '{1'b1, FacePosX, 12'd255, 12'd128});      // x/y tie
    add_row(0, -7, 7, 1, '{1'b1, FaceNegY, 12'd128, 12'd255});     // y/z tie
    add_row(7, 0, -7, 1, '{1'b1, FacePosX, 12'd128, 12'd0});       // x/z tie
    add_row(-9, 2, -9, 0, '0);
    add_row(0, 6, -6, 0, '0);
    add_row(3, -2, 10, 0, '0);
    add_row(100, -37, 61, 0, '0);
    add_row(-4, 9, -2, 0, '0);
    add_row(12345, -67890, 222222, 0, '0);
    add_row(-1, -1, -2, 0, '0);
    add_row(8388607, -8388608, 1, 0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_dir(dir_tab[i]);

    // Random phases: a new grid size each time, cycling through the idle rates.
    foreach (grid_plan[p]) begin
      write_grid(grid_plan[p]);
      idle_pct = idle_plan[p % 3];
      repeat (ItemsPerPhase) begin
        row.dir = rand_dir();
        row.typed = 1'b0;
        row.exp_res = '0;
        send_dir(row);
      end
    end

    start_drv <= 1'b0;
    @(posedge clk_i);
    while (cell_q.size() != 0) @(posedge clk_i);
    // hold a little longer to catch stray strobes
    repeat (2 * LatencyCycles) @(posedge clk_i);

    if (mismatches == 0 && cell_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> cube_face_grid_location.f
sv/cfgl_pkg.sv
sv/cfgl_face_sel.sv
sv/cfgl_div_cell.sv
sv/cube_face_grid_location.sv
sv/cfgl_checker.sv
tb/tb_cube_face_grid_location.sv
